FILE: hdl/lkvc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the key-value cache with recency ordering.
// No dependencies; used by the storage cells and by the top level.
package lkvc_pkg;

  localparam int DATA_W  = 32;
  localparam int CFG_W   = 5;
  localparam int ADDR_W  = 3;
  localparam int PDATA_W = 32;

  localparam logic [CFG_W-1:0] CAP_RESET = 5'd16;

  localparam logic CMD_GET = 1'b0;
  localparam logic CMD_PUT = 1'b1;

  // Register index, taken from the word address bit of paddr.
  localparam logic REG_CAPACITY = 1'b0;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_SEL,
    S_UPD
  } state_t;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_HIT,
    OP_EVICT,
    OP_INSERT
  } op_t;

  typedef struct packed {
    logic              valid;
    logic [DATA_W-1:0] key;
    logic [DATA_W-1:0] data;
  } entry_t;

  typedef struct packed {
    logic match;
    logic tail;
  } cell_stat_t;

endpackage

FILE: hdl/lkvc_cell.sv
`timescale 1ns / 1ps
// One storage cell of the recency-ordered row: holds a single entry and
// loads its left neighbour's entry on a shift. Depends on lkvc_pkg.
module lkvc_cell (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             shift_en,
  input  lkvc_pkg::entry_t                 left,
  input  logic                             right_valid,
  input  logic [lkvc_pkg::DATA_W-1:0]      req_key,
  output lkvc_pkg::entry_t                 cur,
  output lkvc_pkg::cell_stat_t             stat
);
  import lkvc_pkg::*;

  logic              valid;
  logic [DATA_W-1:0] key;
  logic [DATA_W-1:0] data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (shift_en) begin
      valid <= left.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (shift_en) begin
      key  <= left.key;
      data <= left.data;
    end
  end

  // The last valid cell of the row holds the least recent entry.
  always_ff @(posedge clk) begin
    stat.match <= valid && (key == req_key);
    stat.tail  <= valid && !right_valid;
  end

  assign cur = '{valid: valid, key: key, data: data};

endmodule

FILE: hdl/lru_key_value_cache.sv
`timescale 1ns / 1ps
// Key-value cache with least-recently-used replacement, built as a row of cells
// kept in recency order (most recent in cell 0). Depends on lkvc_pkg, lkvc_cell.
// An input beat is registered, then handled in the compare, select and update states;
// the result is registered. One item is in flight at a time (compare, select, shift the cell row).
// A stalled result delays the shift; the next beat is taken once the shift is done.
// Reset clears every valid bit and the fill count and sets the capacity to 16.
module lru_key_value_cache #(
  parameter int ENTRIES = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [lkvc_pkg::ADDR_W-1:0]     paddr,
  input  logic [lkvc_pkg::PDATA_W-1:0]    pwdata,
  output logic [lkvc_pkg::PDATA_W-1:0]    prdata,
  output logic                            pready,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            command,
  input  logic signed [31:0]              key,
  input  logic signed [31:0]              write_value,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            found,
  output logic signed [31:0]              read_value,
  output logic                            evicted,
  output logic signed [31:0]              evicted_key
);
  import lkvc_pkg::*;

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int W  = (CW > CFG_W) ? CW : CFG_W;

  // Configuration.
  logic [CFG_W-1:0] capacity;
  logic [W-1:0]     cap_w;
  logic [W-1:0]     cap_eff;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == REG_CAPACITY)) begin
      capacity <= pwdata[CFG_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_CAPACITY) begin
      prdata = {{(PDATA_W-CFG_W){1'b0}}, capacity};
    end
  end

  always_comb begin
    cap_w = W'(capacity);
    priority if (cap_w == '0) begin
      cap_eff = W'(1);
    end else if (cap_w > W'(ENTRIES)) begin
      cap_eff = W'(ENTRIES);
    end else begin
      cap_eff = cap_w;
    end
  end

  // Control.
  state_t state, state_next;
  logic   upd_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    upd_go     = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          state_next = S_CMP;
        end
      end
      S_CMP: begin
        state_next = S_SEL;
      end
      S_SEL: begin
        state_next = S_UPD;
      end
      S_UPD: begin
        if (!out_valid || !out_stall) begin
          upd_go     = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Request registers.
  logic              req_cmd;
  logic [DATA_W-1:0] req_key;
  logic [DATA_W-1:0] req_val;

  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      req_cmd <= command;
      req_key <= key;
      req_val <= write_value;
    end
  end

  // Cell row.
  entry_t          cells [ENTRIES];
  cell_stat_t      stats [ENTRIES];
  logic [ENTRIES-1:0] valid_vec;
  logic [ENTRIES-1:0] shift_vec;
  entry_t          new_entry;
  op_t             op;
  logic [IW-1:0]   pos;
  logic [DATA_W-1:0] hit_data;
  logic [DATA_W-1:0] tail_key;
  logic [CW-1:0]   count;

  assign new_entry = '{valid: 1'b1, key: req_key,
                       data: (op == OP_HIT && req_cmd == CMD_GET) ? hit_data : req_val};

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    entry_t left;
    logic   right_valid;

    if (i == 0) begin : g_first
      assign left = new_entry;
    end else begin : g_rest
      assign left = cells[i-1];
    end

    if (i == ENTRIES - 1) begin : g_last
      assign right_valid = 1'b0;
    end else begin : g_inner
      assign right_valid = cells[i+1].valid;
    end

    assign shift_vec[i] = upd_go && (op != OP_NONE) && (IW'(i) <= pos);
    assign valid_vec[i] = cells[i].valid;

    lkvc_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .shift_en    (shift_vec[i]),
      .left        (left),
      .right_valid (right_valid),
      .req_key     (req_key),
      .cur         (cells[i]),
      .stat        (stats[i])
    );
  end

  // Selection over the row.
  logic              sel_hit;
  logic [IW-1:0]     sel_pos;
  logic [DATA_W-1:0] sel_data;
  logic [DATA_W-1:0] sel_tail;
  logic              full;
  logic [ENTRIES-1:0] match_vec;

  always_comb begin
    sel_hit  = 1'b0;
    sel_pos  = '0;
    sel_data = '0;
    sel_tail = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      match_vec[i] = stats[i].match;
      sel_hit  = sel_hit | stats[i].match;
      sel_pos  = sel_pos | (stats[i].match ? IW'(i) : '0);
      sel_data = sel_data | (stats[i].match ? cells[i].data : '0);
      sel_tail = sel_tail | (stats[i].tail ? cells[i].key : '0);
    end
  end

  assign full = W'(count) >= cap_eff;

  always_ff @(posedge clk) begin
    if (state == S_SEL) begin
      hit_data <= sel_data;
      tail_key <= sel_tail;
      priority if (sel_hit) begin
        op  <= OP_HIT;
        pos <= sel_pos;
      end else if (req_cmd == CMD_GET) begin
        op  <= OP_NONE;
        pos <= '0;
      end else if (full) begin
        op  <= OP_EVICT;
        pos <= IW'(count - CW'(1));
      end else begin
        op  <= OP_INSERT;
        pos <= IW'(count);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (upd_go && op == OP_INSERT) begin
      count <= count + CW'(1);
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (upd_go) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (upd_go) begin
      found       <= (op == OP_HIT);
      read_value  <= (op == OP_HIT && req_cmd == CMD_GET) ? hit_data : '0;
      evicted     <= (op == OP_EVICT);
      evicted_key <= (op == OP_EVICT) ? tail_key : '0;
    end
  end

  // Checks.
  a_single_match: assert property (@(posedge clk) disable iff (rst)
    state == S_SEL |-> $onehot0(match_vec))
    else $error("more than one cell matched the key");

  a_count_packed: assert property (@(posedge clk) disable iff (rst)
    $countones(valid_vec) == int'(count))
    else $error("fill count disagrees with the valid cells");

  a_row_packed: assert property (@(posedge clk) disable iff (rst)
    count != '0 |-> valid_vec[0])
    else $error("valid cells are not packed at the front of the row");

  a_result_from_update: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_UPD)
    else $error("result offered outside the update step");

endmodule

FILE: tb/tb_lru_key_value_cache.sv
`timescale 1ns / 1ps
// Self-checking testbench for lru_key_value_cache: a driver and a monitor with random idling,
// checked against a behavioural model of the recency-ordered store. Depends on lkvc_pkg.
module tb_lru_key_value_cache;
  import lkvc_pkg::*;

  localparam int ENTRIES = 16;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 8;
  localparam logic [ADDR_W-1:0] CAPACITY_ADDR = 3'd0;
  localparam logic [ADDR_W-1:0] SPARE_ADDR = 3'd4;
  localparam logic [31:0] BOUNDARY_WORDS [4] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0,
                                                 32'hFFFF_FFFF};

  typedef struct packed {
    logic        command;
    logic [31:0] key;
    logic [31:0] write_value;
  } cache_access_t;

  typedef struct packed {
    logic        found;
    logic [31:0] read_value;
    logic        evicted;
    logic [31:0] evicted_key;
  } cache_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_stall;
  logic command = CMD_GET;
  logic signed [31:0] key = '0;
  logic signed [31:0] write_value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic found;
  logic signed [31:0] read_value;
  logic evicted;
  logic signed [31:0] evicted_key;

  cache_access_t pending_accesses[$];
  cache_result_t expected_results[$];
  int mismatch_count = 0;
  int idle_pct = 30;
  int stall_pct = 30;
  int quiet_cycles = 0;

  logic        model_valid [ENTRIES];
  logic [31:0] model_key   [ENTRIES];
  logic [31:0] model_data  [ENTRIES];
  int          model_rank  [ENTRIES];
  logic [CFG_W-1:0] capacity_setting = CAP_RESET;

  lru_key_value_cache #(.ENTRIES(ENTRIES)) dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall),
    .command(command), .key(key), .write_value(write_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .found(found), .read_value(read_value), .evicted(evicted), .evicted_key(evicted_key)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int effective_capacity();
    int cap;
    cap = int'(capacity_setting);
    if (cap == 0) cap = 1;
    if (cap > ENTRIES) cap = ENTRIES;
    return cap;
  endfunction

  function automatic void make_recent(int slot, int old_rank);
    for (int i = 0; i < ENTRIES; i++) begin
      if (model_valid[i] && i != slot && model_rank[i] < old_rank) model_rank[i]++;
    end
    model_rank[slot] = 0;
  endfunction

  function automatic cache_result_t apply_access(cache_access_t acc);
    cache_result_t res;
    int hit;
    int free_slot;
    int lru;
    int slot;
    int fill;
    res = '0;
    hit = -1;
    free_slot = -1;
    lru = -1;
    slot = -1;
    fill = 0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (model_valid[i]) begin
        fill++;
        if (model_key[i] == acc.key) hit = i;
        if (lru < 0 || model_rank[i] > model_rank[lru]) lru = i;
      end else if (free_slot < 0) begin
        free_slot = i;
      end
    end
    if (hit >= 0) begin
      res.found = 1'b1;
      if (acc.command == CMD_GET) res.read_value = model_data[hit];
      else model_data[hit] = acc.write_value;
      make_recent(hit, model_rank[hit]);
    end else if (acc.command == CMD_PUT) begin
      if (fill >= effective_capacity() && lru >= 0) begin
        res.evicted = 1'b1;
        res.evicted_key = model_key[lru];
        slot = lru;
        make_recent(slot, model_rank[lru]);
      end else if (free_slot >= 0) begin
        slot = free_slot;
        model_valid[slot] = 1'b1;
        make_recent(slot, ENTRIES);
      end
      if (slot >= 0) begin
        model_key[slot] = acc.key;
        model_data[slot] = acc.write_value;
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin : drive_beats
    cache_access_t next_access;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_results.push_back(apply_access({command, key, write_value}));
      end
      if (!in_valid || !in_stall) begin
        if (pending_accesses.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
          next_access = pending_accesses.pop_front();
          in_valid <= 1'b1;
          command <= next_access.command;
          key <= next_access.key;
          write_value <= next_access.write_value;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatch_count++;
      $display("%0t ns: %s mismatch, expected %h, got %h", $time, field, want, got);
    end
  endtask

  always @(posedge clk) begin : watch_results
    cache_result_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          mismatch_count++;
          $display("%0t ns: result beat with nothing expected, found %b read_value %h",
                   $time, found, read_value);
        end else begin
          want = expected_results.pop_front();
          check_field("found", 32'(want.found), 32'(found));
          check_field("read_value", want.read_value, read_value);
          check_field("evicted", 32'(want.evicted), 32'(evicted));
          check_field("evicted_key", want.evicted_key, evicted_key);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (psel && penable && pready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog expired at %0t ns with %0d results outstanding",
               $time, expected_results.size());
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic queue_access(logic cmd, logic [31:0] k, logic [31:0] v);
    pending_accesses.push_back({cmd, k, v});
  endtask

  task automatic wait_until_idle();
    while (pending_accesses.size() != 0 || in_valid || expected_results.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_register(logic [ADDR_W-1:0] addr, logic [31:0] data);
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr[2] == REG_CAPACITY) capacity_setting = data[CFG_W-1:0];
  endtask

  function automatic logic [31:0] random_word();
    if ($urandom_range(0, 7) == 0) return BOUNDARY_WORDS[$urandom_range(0, 3)];
    return $urandom;
  endfunction

  initial begin : stimulus
    int phase_caps [10];
    logic [31:0] key_pool[];
    logic [31:0] cfg_word;
    logic [31:0] k;
    phase_caps = '{16, 1, 5, 31, 0, 8, 3, 16, 12, 2};
    for (int i = 0; i < ENTRIES; i++) begin
      model_valid[i] = 1'b0;
      model_key[i] = '0;
      model_data[i] = '0;
      model_rank[i] = 0;
    end
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    queue_access(CMD_GET, 32'h0, 32'hFFFF_FFFF);
    queue_access(CMD_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
    queue_access(CMD_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
    queue_access(CMD_PUT, 32'h0, 32'h0);
    queue_access(CMD_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_access(CMD_GET, 32'h8000_0000, 32'h0);
    queue_access(CMD_GET, 32'hFFFF_FFFF, 32'h5555_5555);
    queue_access(CMD_PUT, 32'h0, 32'h1234_5678);
    queue_access(CMD_GET, 32'h0, 32'h0);
    queue_access(CMD_GET, 32'h5, 32'h0);
    queue_access(CMD_GET, 32'h7FFF_FFFF, 32'h0);
    wait_until_idle();

    write_register(SPARE_ADDR, 32'd3);
    queue_access(CMD_PUT, 32'd100, 32'hAAAA_AAAA);
    queue_access(CMD_PUT, 32'd101, 32'h5555_5555);
    wait_until_idle();

    // Capacity now below occupancy: each new key replaces the least recent entry.
    write_register(CAPACITY_ADDR, 32'd2);
    queue_access(CMD_PUT, 32'd102, 32'h0000_0001);
    queue_access(CMD_PUT, 32'd103, 32'h0000_0002);
    queue_access(CMD_GET, 32'd102, 32'h0);
    wait_until_idle();

    write_register(CAPACITY_ADDR, 32'd0);
    queue_access(CMD_PUT, 32'd104, 32'h0000_0003);
    queue_access(CMD_PUT, 32'd105, 32'h0000_0004);
    queue_access(CMD_GET, 32'd105, 32'h0);
    wait_until_idle();

    write_register(CAPACITY_ADDR, 32'd31);
    queue_access(CMD_PUT, 32'd106, 32'hFFFF_0000);
    wait_until_idle();

    foreach (phase_caps[p]) begin
      cfg_word = $urandom;
      cfg_word[CFG_W-1:0] = CFG_W'(phase_caps[p]);
      write_register(p % 3 == 2 ? SPARE_ADDR : CAPACITY_ADDR, $urandom);
      write_register(CAPACITY_ADDR, cfg_word);
      idle_pct = (p == 7) ? 0 : 30;
      stall_pct = (p == 7) ? 0 : 30;
      key_pool = new[effective_capacity() + $urandom_range(1, 8)];
      foreach (key_pool[i]) key_pool[i] = random_word();
      for (int n = 0; n < 143; n++) begin
        k = ($urandom_range(0, 99) < 85) ? key_pool[$urandom_range(0, key_pool.size() - 1)]
                                         : $urandom;
        queue_access(1'($urandom_range(0, 1)), k, random_word());
      end
      wait_until_idle();
    end

    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
